// ===== rtl/mbt_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time test block.
package mbt_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_IN_USE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BOUND    = 3'd6;

    // Configuration register file contents
    typedef struct packed {
        logic [31:0] left_edge;
        logic [31:0] top_edge;
        logic [30:0] column_step;
        logic [30:0] row_step;
        logic [15:0] columns_in_use;
        logic [15:0] iteration_limit;
        logic [30:0] escape_bound;
    } t_cfg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // take a new pixel, clear the iteration state
        logic div_step;   // one restoring division step
        logic coord_mul;  // column and row times their steps
        logic coord_add;  // add the edges, giving c
        logic iter_mul;   // register the three products of z
        logic iter_upd;   // z = z^2 + c, count up
        logic out_load;   // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;   // this division step is the final one
        logic stop;       // escaped or iteration limit reached
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

// ===== rtl/mbt_ctrl.sv =====
// Sequencing state machine for the Mandelbrot escape-time test.
module mbt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  mbt_pkg::t_sts i_sts,
    output mbt_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_CMUL  = 3'd2;
    localparam logic [2:0] ST_CADD  = 3'd3;
    localparam logic [2:0] ST_IMUL  = 3'd4;
    localparam logic [2:0] ST_ICHK  = 3'd5;
    localparam logic [2:0] ST_WRITE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_CMUL;
                end
            end
            ST_CMUL: begin
                o_cmd.coord_mul = 1'b1;
                n_state         = ST_CADD;
            end
            ST_CADD: begin
                o_cmd.coord_add = 1'b1;
                n_state         = ST_IMUL;
            end
            ST_IMUL: begin
                o_cmd.iter_mul = 1'b1;
                n_state        = ST_ICHK;
            end
            ST_ICHK: begin
                if (i_sts.stop) begin
                    n_state = ST_WRITE;
                end else begin
                    o_cmd.iter_upd = 1'b1;
                    n_state        = ST_IMUL;
                end
            end
            ST_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== rtl/mbt_dp.sv =====
// Datapath: index division, point mapping, z^2 + c iteration and output register.
module mbt_dp #(
    parameter int INDEX_BITS = 20,
    parameter int FRAC_BITS  = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mbt_pkg::t_cfg         i_cfg,
    input  mbt_pkg::t_cmd         i_cmd,
    output mbt_pkg::t_sts         o_sts,
    input  logic [INDEX_BITS-1:0] i_pixel_index,
    input  logic                  i_last_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_in_set,
    output logic                  o_last_result
);

    localparam int CNT_W = $clog2(INDEX_BITS);

    // Division state: quotient shifts in where the dividend shifts out
    logic [INDEX_BITS-1:0] r_quo;
    logic [15:0]           r_rem;
    logic [CNT_W-1:0]      r_div_cnt;
    logic                  r_last;

    // Point and iteration state
    logic [31:0]        r_cprod;
    logic [31:0]        r_rprod;
    logic [31:0]        r_cr;
    logic [31:0]        r_ci;
    logic signed [31:0] r_zr;
    logic signed [31:0] r_zi;
    logic signed [63:0] r_prr;
    logic signed [63:0] r_pii;
    logic signed [63:0] r_pri;
    logic [15:0]        r_count;

    // Output register
    logic r_out_valid;
    logic r_out_in_set;
    logic r_out_last;

    logic [15:0]              cols_eff;
    logic [16:0]              rem_sh;
    logic                     quo_bit;
    logic [46:0]              col_mul;
    logic [INDEX_BITS+30:0]   row_mul;
    logic signed [63:0]       prr;
    logic signed [63:0]       pii;
    logic signed [63:0]       pri;
    logic [63:0]              norm_sum;
    logic [63:0]              norm;
    logic                     escaped;
    logic [31:0]              rr;
    logic [31:0]              ii;
    logic [31:0]              ri;

    // Restoring division step, a zero column count acts as one
    assign cols_eff = (i_cfg.columns_in_use == 16'd0) ? 16'd1 : i_cfg.columns_in_use;
    assign rem_sh   = {r_rem, r_quo[INDEX_BITS-1]};
    assign quo_bit  = (rem_sh >= {1'b0, cols_eff});

    // Coordinate products, only the low word survives the wrap
    assign col_mul = r_rem * i_cfg.column_step;
    assign row_mul = r_quo * i_cfg.row_step;

    // Products of z
    assign prr = r_zr * r_zr;
    assign pii = r_zi * r_zi;
    assign pri = r_zr * r_zi;

    // Squared magnitude is exact: both squares are non-negative
    assign norm_sum = 64'(r_prr) + 64'(r_pii);
    assign norm     = norm_sum >> FRAC_BITS;
    assign escaped  = (norm > {33'd0, i_cfg.escape_bound});

    // Fixed-point products, floor shift and wrap
    assign rr = r_prr[FRAC_BITS+31:FRAC_BITS];
    assign ii = r_pii[FRAC_BITS+31:FRAC_BITS];
    assign ri = r_pri[FRAC_BITS+31:FRAC_BITS];

    assign o_sts.div_last = (r_div_cnt == CNT_W'(INDEX_BITS - 1));
    assign o_sts.stop     = escaped || (r_count >= i_cfg.iteration_limit);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Division registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo     <= i_pixel_index;
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_last    <= i_last_pixel;
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[INDEX_BITS-2:0], quo_bit};
            r_rem     <= quo_bit ? 16'(rem_sh - {1'b0, cols_eff}) : rem_sh[15:0];
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // Point mapping
    always_ff @(posedge i_clk) begin
        if (i_cmd.coord_mul) begin
            r_cprod <= col_mul[31:0];
            r_rprod <= row_mul[31:0];
        end
        if (i_cmd.coord_add) begin
            r_cr <= i_cfg.left_edge + r_cprod;
            r_ci <= i_cfg.top_edge - r_rprod;
        end
    end

    // Iteration z = z^2 + c
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end else if (i_cmd.iter_upd) begin
            r_zr    <= rr - ii + r_cr;
            r_zi    <= {ri[30:0], 1'b0} + r_ci;
            r_count <= r_count + 16'd1;
        end
        if (i_cmd.iter_mul) begin
            r_prr <= prr;
            r_pii <= pii;
            r_pri <= pri;
        end
    end

    // Output register, holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_in_set <= (r_count == i_cfg.iteration_limit);
            r_out_last   <= r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_in_set      = r_out_in_set;
    assign o_last_result = r_out_last;

endmodule

// ===== rtl/mandelbrot_escape_test_top.sv =====
// An accepted transaction is worked through the division steps, the coordinate products and sums
// and the iterations, at most iteration_limit of them, each registering the products of z before
// the z update; the result then goes into the output register once that register is free.
// One pixel is in work at a time; the next pixel is taken while a finished result waits in the
// output register.
// Reset (synchronous, active low) idles the controller, drops the output valid, loads the default view.
module mandelbrot_escape_test_top #(
    parameter int INDEX_BITS = 20,
    parameter int FRAC_BITS  = 28
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [INDEX_BITS-1:0]              i_pixel_index,
    input  logic                               i_last_pixel,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_in_set,
    output logic                               o_last_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);

    // Default view in the chosen fixed-point format
    localparam longint ONE       = 64'sd1 <<< FRAC_BITS;
    localparam longint RST_LEFT  = -((ONE * 3) / 2);
    localparam longint RST_TOP   = ONE;
    localparam longint RST_CSTEP = ((ONE * 5) / 2) / 15;
    localparam longint RST_RSTEP = (ONE * 2) / 15;
    localparam longint RST_BOUND = ONE * 4;

    mbt_pkg::t_cfg r_cfg;
    mbt_pkg::t_cmd cmd;
    mbt_pkg::t_sts sts;

    // Configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_edge       <= RST_LEFT[31:0];
            r_cfg.top_edge        <= RST_TOP[31:0];
            r_cfg.column_step     <= RST_CSTEP[30:0];
            r_cfg.row_step        <= RST_RSTEP[30:0];
            r_cfg.columns_in_use  <= 16'd16;
            r_cfg.iteration_limit <= 16'd1000;
            r_cfg.escape_bound    <= RST_BOUND[30:0];
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mbt_pkg::REG_LEFT_EDGE:       r_cfg.left_edge       <= i_cfg_data;
                mbt_pkg::REG_TOP_EDGE:        r_cfg.top_edge        <= i_cfg_data;
                mbt_pkg::REG_COLUMN_STEP:     r_cfg.column_step     <= i_cfg_data[30:0];
                mbt_pkg::REG_ROW_STEP:        r_cfg.row_step        <= i_cfg_data[30:0];
                mbt_pkg::REG_COLUMNS_IN_USE:  r_cfg.columns_in_use  <= i_cfg_data[15:0];
                mbt_pkg::REG_ITERATION_LIMIT: r_cfg.iteration_limit <= i_cfg_data[15:0];
                mbt_pkg::REG_ESCAPE_BOUND:    r_cfg.escape_bound    <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Controller
    mbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath
    mbt_dp #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pixel_index (i_pixel_index),
        .i_last_pixel  (i_last_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_in_set      (o_in_set),
        .o_last_result (o_last_result)
    );

endmodule

// ===== rtl/mbt_checker.sv =====
// Port-level checks for the Mandelbrot escape-time test, bound to the top level.
module mbt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_in_set,
    input logic o_last_result
);

    // A stalled result stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_in_set)
            && $stable(o_last_result))
        else $error("result changed while stalled");

    // Reset leaves the block idle with no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the block");

    // An accepted transaction keeps the input stalled while work on it begins
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall)
        else $error("input not stalled after a transaction");

    // A new result only appears at the end of work on a pixel
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a pixel in work");

endmodule

bind mandelbrot_escape_test_top mbt_checker u_mbt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_in_set      (o_in_set),
    .o_last_result (o_last_result)
);

// ===== verif/mandelbrot_escape_test_top_tb.sv =====
// Self-checking testbench for the Mandelbrot escape-time membership block.
module mandelbrot_escape_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INDEX_W = 20;
    localparam int FRAC    = 28;

    // No register sits at this index; writes to it must be dropped
    localparam logic [mbt_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

    // Q4.28 constants for the random views
    localparam logic [31:0] LEFT_NOMINAL = 32'hDC00_0000;   // -2.25
    localparam logic [31:0] TOP_NOMINAL  = 32'h1400_0000;   // 1.25
    localparam int unsigned SPAN_REAL    = 32'd805306368;   // 3.0
    localparam int unsigned SPAN_IMAG    = 32'd671088640;   // 2.5
    localparam int unsigned BOUND_FOUR   = 32'd1073741824;  // 4.0
    localparam int unsigned BOUND_TWO    = 32'd536870912;   // 2.0

    localparam int RANDOM_VIEWS    = 8;
    localparam int PIXELS_PER_VIEW = 75;
    localparam int PRESSURE_HOLD   = 2000;
    localparam int WATCHDOG_LIMIT  = 400000;

    typedef struct {
        bit [INDEX_W-1:0] index;
        bit               last;
    } t_pixel;

    typedef struct {
        bit [INDEX_W-1:0] pixel;
        bit               in_set;
        bit               last;
    } t_pixel_verdict;

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic [INDEX_W-1:0]            pixel_index  = '0;
    logic                          last_pixel   = 1'b0;
    logic                          out_stall    = 1'b0;
    logic                          cfg_valid    = 1'b0;
    logic [mbt_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [31:0]                   cfg_data     = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic                          o_in_set;
    logic                          o_last_result;
    logic                          o_cfg_ready;

    // Shadow of the register file
    mbt_pkg::t_cfg view;

    t_pixel         pixel_q[$];
    t_pixel_verdict verdict_q[$];

    int pixels_queued    = 0;
    int pixels_offered   = 0;
    int pixels_accepted  = 0;
    int results_checked  = 0;
    int results_in_set   = 0;
    int reg_writes       = 0;
    int views_run        = 0;
    int error_count      = 0;
    int gap_left         = 0;
    int stall_left       = 0;
    int hold_left        = 0;
    int hold_requests    = 0;
    int holds_done       = 0;
    int idle_cycles      = 0;
    bit calm             = 1'b0;

    mandelbrot_escape_test_top #(
        .INDEX_BITS (INDEX_W),
        .FRAC_BITS  (FRAC)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_index (pixel_index),
        .i_last_pixel  (last_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_in_set      (o_in_set),
        .o_last_result (o_last_result),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // 2 ns clock
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Fixed-point product: exact, floor shift, wrapped to 32 bits
    function automatic bit [31:0] fixed_mul(bit [31:0] a, bit [31:0] b);
        bit [63:0] p;
        p = longint'($signed(a)) * longint'($signed(b));
        return p[FRAC+31:FRAC];
    endfunction

    function automatic bit [63:0] magnitude64(bit [31:0] v);
        longint s;
        s = longint'($signed(v));
        return (s < 0) ? -s : s;
    endfunction

    // Escape-time iteration for one pixel under the current view
    function automatic bit mandel_in_set(bit [INDEX_W-1:0] pixel);
        bit [63:0]   cols, col, row, prod, mag_re, mag_im, norm;
        bit [31:0]   c_re, c_im, z_re, z_im, sq_re, sq_im, sq_ri;
        int unsigned count;
        cols   = (view.columns_in_use == 0) ? 64'd1 : 64'(view.columns_in_use);
        col    = 64'(pixel) % cols;
        row    = 64'(pixel) / cols;
        prod   = col * 64'(view.column_step);
        c_re   = view.left_edge + prod[31:0];
        prod   = row * 64'(view.row_step);
        c_im   = view.top_edge - prod[31:0];
        z_re   = '0;
        z_im   = '0;
        count  = 0;
        forever begin
            mag_re = magnitude64(z_re);
            mag_im = magnitude64(z_im);
            norm   = (mag_re * mag_re + mag_im * mag_im) >> FRAC;
            if (norm > 64'(view.escape_bound) || count >= view.iteration_limit)
                break;
            sq_re = fixed_mul(z_re, z_re);
            sq_im = fixed_mul(z_im, z_im);
            sq_ri = fixed_mul(z_re, z_im);
            z_re  = sq_re - sq_im + c_re;
            z_im  = sq_ri + sq_ri + c_im;
            count++;
        end
        return count == view.iteration_limit;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(15, 4);
        return $urandom_range(80, 20);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Pixel driver: presents queued pixels with random gaps
    always @(negedge clk) begin : pixel_driver
        t_pixel item;
        if (rst_n && (!in_valid || pixels_accepted == pixels_offered)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                item = pixel_q.pop_front();
                in_valid    <= 1'b1;
                pixel_index <= item.index;
                last_pixel  <= item.last;
                pixels_offered++;
                gap_left = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus long holds on request
    always @(negedge clk) begin : result_stall
        bit stall_next;
        stall_next = 1'b0;
        if (rst_n) begin
            if (holds_done != hold_requests) begin
                hold_left = PRESSURE_HOLD;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else if (!calm && $urandom_range(3) == 0) begin
                stall_left = pick_gap();
            end
            out_stall <= stall_next;
        end
    end

    // Monitor: predict on each accepted pixel, check each accepted result
    always @(posedge clk) begin : monitor
        t_pixel_verdict v;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                v.pixel  = pixel_index;
                v.in_set = mandel_in_set(pixel_index);
                v.last   = last_pixel;
                verdict_q.push_back(v);
                pixels_accepted++;
            end
            if (o_out_valid && !out_stall) begin
                results_checked++;
                if (verdict_q.size() == 0) begin
                    note_error("result transaction with no pixel outstanding");
                end else begin
                    v = verdict_q.pop_front();
                    if (v.in_set)
                        results_in_set++;
                    if (o_in_set !== v.in_set)
                        note_error($sformatf("pixel %0d: in_set expected %0b, got %0b",
                                             v.pixel, v.in_set, o_in_set));
                    if (o_last_result !== v.last)
                        note_error($sformatf("pixel %0d: last expected %0b, got %0b",
                                             v.pixel, v.last, o_last_result));
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
            || (cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, verdict_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [mbt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            mbt_pkg::REG_LEFT_EDGE:       view.left_edge       = data;
            mbt_pkg::REG_TOP_EDGE:        view.top_edge        = data;
            mbt_pkg::REG_COLUMN_STEP:     view.column_step     = data[30:0];
            mbt_pkg::REG_ROW_STEP:        view.row_step        = data[30:0];
            mbt_pkg::REG_COLUMNS_IN_USE:  view.columns_in_use  = data[15:0];
            mbt_pkg::REG_ITERATION_LIMIT: view.iteration_limit = data[15:0];
            mbt_pkg::REG_ESCAPE_BOUND:    view.escape_bound    = data[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(input bit [INDEX_W-1:0] idx, input bit last);
        t_pixel item;
        item.index = idx;
        item.last  = last;
        pixel_q.push_back(item);
        pixels_queued++;
    endtask

    // Block until every queued pixel is in and every result is out
    task automatic wait_quiet();
        while (pixel_q.size() != 0 || pixels_accepted != pixels_queued
               || verdict_q.size() != 0)
            @(negedge clk);
        views_run++;
    endtask

    // New view: a window around the set, or raw random values when wild
    task automatic load_random_view(input bit wild, output int unsigned grid);
        int unsigned cols, limit, bound, pick;
        longint      cells;
        cols  = ($urandom_range(9) == 0) ? $urandom_range(65535, 1024)
                                         : $urandom_range(64, 2);
        limit = ($urandom_range(9) == 0) ? $urandom_range(400, 150)
                                         : $urandom_range(100, 1);
        pick  = $urandom_range(19);
        bound = (pick < 14) ? BOUND_FOUR :
                (pick < 17) ? BOUND_TWO : $urandom_range(32'h7FFF_FFFF, 0);
        if (wild) begin
            write_reg(mbt_pkg::REG_LEFT_EDGE, $urandom());
            write_reg(mbt_pkg::REG_TOP_EDGE, $urandom());
            write_reg(mbt_pkg::REG_COLUMN_STEP, $urandom());
            write_reg(mbt_pkg::REG_ROW_STEP, $urandom());
        end else begin
            write_reg(mbt_pkg::REG_LEFT_EDGE,
                      LEFT_NOMINAL + $urandom_range(32'h0400_0000, 0));
            write_reg(mbt_pkg::REG_TOP_EDGE,
                      TOP_NOMINAL - $urandom_range(32'h0400_0000, 0));
            write_reg(mbt_pkg::REG_COLUMN_STEP, {1'($urandom()), 31'(SPAN_REAL / cols)});
            write_reg(mbt_pkg::REG_ROW_STEP, {1'($urandom()), 31'(SPAN_IMAG / cols)});
        end
        // upper bits carry junk that the block must ignore
        write_reg(mbt_pkg::REG_COLUMNS_IN_USE, {16'($urandom()), 16'(cols)});
        write_reg(mbt_pkg::REG_ITERATION_LIMIT, {16'($urandom()), 16'(limit)});
        write_reg(mbt_pkg::REG_ESCAPE_BOUND, {1'($urandom()), 31'(bound)});
        cells = longint'(cols) * longint'(cols);
        grid  = (cells > 64'd1048576) ? 32'd1048576 : 32'(cells);
    endtask

    initial begin : stimulus
        int unsigned grid;
        bit [INDEX_W-1:0] idx;

        view.left_edge       = 32'hE800_0000;
        view.top_edge        = 32'd268435456;
        view.column_step     = 31'd44739242;
        view.row_step        = 31'd35791394;
        view.columns_in_use  = 16'd16;
        view.iteration_limit = 16'd1000;
        view.escape_bound    = 31'd1073741824;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default view: corners, centre of the grid, index extremes
        queue_pixel(20'd0, 1'b0);
        queue_pixel(20'd15, 1'b0);
        queue_pixel(20'd16, 1'b1);
        queue_pixel(20'd136, 1'b1);
        queue_pixel(20'd120, 1'b0);
        queue_pixel(20'd72, 1'b0);
        queue_pixel(20'd183, 1'b1);
        queue_pixel(20'd255, 1'b0);
        queue_pixel(20'd524288, 1'b0);
        queue_pixel(20'hF_FFFF, 1'b1);
        wait_quiet();

        // Point at the origin with the largest limit and bound
        write_reg(mbt_pkg::REG_LEFT_EDGE, 32'd0);
        write_reg(mbt_pkg::REG_TOP_EDGE, 32'd0);
        write_reg(mbt_pkg::REG_COLUMN_STEP, 32'd0);
        write_reg(mbt_pkg::REG_ROW_STEP, 32'd0);
        write_reg(mbt_pkg::REG_COLUMNS_IN_USE, 32'd2);
        write_reg(mbt_pkg::REG_ITERATION_LIMIT, 32'h0000_FFFF);
        write_reg(mbt_pkg::REG_ESCAPE_BOUND, 32'h7FFF_FFFF);
        queue_pixel(20'($urandom()), 1'b1);
        wait_quiet();

        // Extreme register values, zero bound, single iteration
        write_reg(mbt_pkg::REG_LEFT_EDGE, 32'h8000_0000);
        write_reg(mbt_pkg::REG_TOP_EDGE, 32'h7FFF_FFFF);
        write_reg(mbt_pkg::REG_COLUMN_STEP, 32'hFFFF_FFFF);
        write_reg(mbt_pkg::REG_ROW_STEP, 32'hFFFF_FFFF);
        write_reg(mbt_pkg::REG_COLUMNS_IN_USE, 32'hFFFF_FFFF);
        write_reg(mbt_pkg::REG_ITERATION_LIMIT, 32'hFFFF_0001);
        write_reg(mbt_pkg::REG_ESCAPE_BOUND, 32'h8000_0000);
        write_reg(REG_NONE, $urandom());
        queue_pixel(20'd0, 1'b0);
        queue_pixel(20'd65534, 1'b1);
        queue_pixel(20'd65535, 1'b0);
        queue_pixel(20'hF_FFFF, 1'b1);
        wait_quiet();

        // Zero limit and zero columns
        write_reg(mbt_pkg::REG_ITERATION_LIMIT, 32'd0);
        write_reg(mbt_pkg::REG_COLUMNS_IN_USE, 32'd0);
        queue_pixel(20'd0, 1'b1);
        queue_pixel(20'd5, 1'b0);
        queue_pixel(20'hF_FFFF, 1'b0);
        wait_quiet();

        // Single column, then zero columns, with a real iteration count
        write_reg(mbt_pkg::REG_LEFT_EDGE, 32'hFC00_0000);
        write_reg(mbt_pkg::REG_TOP_EDGE, 32'd0);
        write_reg(mbt_pkg::REG_COLUMN_STEP, 32'd0);
        write_reg(mbt_pkg::REG_ROW_STEP, 32'h0010_0000);
        write_reg(mbt_pkg::REG_ESCAPE_BOUND, BOUND_FOUR);
        write_reg(mbt_pkg::REG_ITERATION_LIMIT, 32'd20);
        write_reg(mbt_pkg::REG_COLUMNS_IN_USE, 32'd1);
        queue_pixel(20'd0, 1'b0);
        queue_pixel(20'd100, 1'b1);
        queue_pixel(20'hF_FFFF, 1'b0);
        wait_quiet();
        write_reg(mbt_pkg::REG_COLUMNS_IN_USE, 32'd0);
        queue_pixel(20'd3, 1'b0);
        queue_pixel(20'd777, 1'b1);
        wait_quiet();

        // Random views: one without idling, one under output back-pressure,
        // one with raw random register values
        for (int p = 0; p < RANDOM_VIEWS; p++) begin
            load_random_view(p == 6, grid);
            calm = (p == 2);
            if (p == 4)
                hold_requests++;
            for (int n = 0; n < PIXELS_PER_VIEW; n++) begin
                idx = ($urandom_range(6) == 0) ? 20'($urandom())
                                               : 20'($urandom_range(grid - 1, 0));
                queue_pixel(idx, $urandom_range(7) == 0);
            end
            wait_quiet();
            calm = 1'b0;
        end

        // Allow any stray result to show up
        repeat (INDEX_W + 10) @(negedge clk);

        $display("Covered %0d pixels over %0d views (%0d register writes);",
                 pixels_accepted, views_run, reg_writes);
        $display("%0d results checked, %0d inside the set, %0d mismatches.",
                 results_checked, results_in_set, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== mandelbrot_escape_test_top.f =====
rtl/mbt_pkg.sv
rtl/mbt_ctrl.sv
rtl/mbt_dp.sv
rtl/mandelbrot_escape_test_top.sv
rtl/mbt_checker.sv
verif/mandelbrot_escape_test_top_tb.sv
